// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/log2h_pkg.sv
package log2h_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int BUCKET_COUNT = 33;
    localparam int COUNT_BITS   = 32;
    localparam int SUM_BITS     = 64;

    localparam int IDX_BITS = $clog2(BUCKET_COUNT);
    localparam int FLS_BITS = $clog2(VALUE_BITS + 1);

    // Fixed field widths of the stream ports.
    localparam int PORT_IDX_BITS = 6;
    localparam int PORT_VAL_BITS = 32;

    typedef enum logic [1:0] {
        CMD_INC   = 2'd0,
        CMD_EVENT = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   addr;
        logic [COUNT_BITS-1:0] data;
    } store_wr_t;

endpackage

// File: hdl/log2_histogram_recorder_top.sv
// Log2 bucket histogram. Each s_ beat is one command: increment the level,
// record an event value (sets the level, adds to the 64-bit sum) or read
// one bucket. Every beat gives exactly one m_ beat carrying the bucket
// touched or read, its count after the update, the level, the high-water
// mark, the total count and the event sum. The block takes one beat per
// cycle unless m_tready holds the output; a beat passes the input stage,
// then the result register. The store clears at reset through per-bucket
// valid bits, so no clearing sweep is needed and beats are taken from the
// first cycle out of reset. Counters wrap at their width.
module log2_histogram_recorder_top
    import log2h_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] event_value, [37:32] read_index, [39:38] zero
    input  logic [39:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] bucket_index, [37:6] bucket_count, [69:38] current_level,
    // [101:70] high_water, [133:102] total_count, [197:134] event_sum,
    // [199:198] zero
    output logic [199:0] m_tdata
);

`include "assert_macros.svh"

    // architectural state
    logic [VALUE_BITS-1:0] level_reg, level_next;
    logic [VALUE_BITS-1:0] peak_reg, peak_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;

    // input stage
    logic                     s1_valid_reg;
    logic                     s1_upd_reg;
    logic                     s1_rng_reg;
    logic [PORT_IDX_BITS-1:0] s1_index_reg;
    logic [IDX_BITS-1:0]      s1_addr_reg;
    logic [VALUE_BITS-1:0]    s1_level_reg;
    logic [VALUE_BITS-1:0]    s1_peak_reg;
    logic [COUNT_BITS-1:0]    s1_total_reg;
    logic [SUM_BITS-1:0]      s1_sum_reg;

    // result register
    logic         m_tvalid_reg;
    logic [199:0] m_tdata_reg;

    cmd_t                     cmd;
    logic [VALUE_BITS-1:0]    ev;
    logic [PORT_IDX_BITS-1:0] rix;
    logic                     is_upd;
    logic                     rix_in_range;
    logic [IDX_BITS-1:0]      fls_bucket;
    logic                     s_accept;
    logic                     advance;
    logic [COUNT_BITS-1:0]    store_count;
    logic [COUNT_BITS-1:0]    cur_count;
    logic [COUNT_BITS-1:0]    new_count;
    store_rd_t                store_rd;
    store_wr_t                store_wr;

    assign cmd = cmd_t'(s_tuser);
    assign ev  = VALUE_BITS'(s_tdata[PORT_VAL_BITS-1:0]);
    assign rix = s_tdata[PORT_VAL_BITS +: PORT_IDX_BITS];

    assign advance  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // next state of the level and the counters
    always_comb begin
        level_next = level_reg;
        sum_next   = sum_reg;
        is_upd     = 1'b1;
        case (cmd)
            CMD_INC: begin
                level_next = level_reg + 1'b1;
            end
            CMD_EVENT: begin
                level_next = ev;
                sum_next   = sum_reg + SUM_BITS'(ev);
            end
            default: begin
                // read (and the unused code) leaves state alone
                is_upd = 1'b0;
            end
        endcase
        total_next = is_upd ? total_reg + 1'b1 : total_reg;
        peak_next  = (is_upd && level_next > peak_reg) ? level_next : peak_reg;
    end

    log2h_fls u_fls (
        .value  (level_next),
        .bucket (fls_bucket)
    );

    assign rix_in_range = int'(rix) < BUCKET_COUNT;

    always_comb begin
        store_rd.en = s_accept;
        if (is_upd) begin
            store_rd.addr = fls_bucket;
        end else if (rix_in_range) begin
            store_rd.addr = IDX_BITS'(rix);
        end else begin
            store_rd.addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            peak_reg  <= '0;
            total_reg <= '0;
            sum_reg   <= '0;
        end else if (s_accept) begin
            level_reg <= level_next;
            peak_reg  <= peak_next;
            total_reg <= total_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_upd_reg   <= is_upd;
            s1_rng_reg   <= is_upd || rix_in_range;
            s1_index_reg <= is_upd ? PORT_IDX_BITS'(fls_bucket) : rix;
            s1_addr_reg  <= store_rd.addr;
            s1_level_reg <= level_next;
            s1_peak_reg  <= peak_next;
            s1_total_reg <= total_next;
            s1_sum_reg   <= sum_next;
        end
    end

    log2h_bucket_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (store_rd),
        .wr      (store_wr),
        .rd_data (store_count)
    );

    // read-modify-write of the bucket; write-back when the beat moves on
    assign cur_count = s1_rng_reg ? store_count : '0;
    assign new_count = s1_upd_reg ? cur_count + 1'b1 : cur_count;

    assign store_wr.en   = advance && s1_upd_reg;
    assign store_wr.addr = s1_addr_reg;
    assign store_wr.data = new_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {2'b00,
                            s1_sum_reg,
                            32'(s1_total_reg),
                            32'(s1_peak_reg),
                            32'(s1_level_reg),
                            32'(new_count),
                            s1_index_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NXT(a_stage_drains, aclk, aresetn, s1_valid_reg && !m_tvalid_reg,
        m_tvalid_reg, "input stage did not move into a free result register")
    `ASSERT_IMP(a_upd_addr_range, aclk, aresetn, s1_valid_reg && s1_upd_reg,
        int'(s1_addr_reg) < BUCKET_COUNT, "update bucket beyond the store")

endmodule

// File: hdl/log2h_fls.sv
module log2h_fls
    import log2h_pkg::*;
(
    input  logic [VALUE_BITS-1:0] value,
    output logic [IDX_BITS-1:0]   bucket
);

    logic [FLS_BITS-1:0] fls;

    // Priority encode: 0 for zero, else msb index plus one.
    always_comb begin
        fls = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (value[i]) begin
                fls = FLS_BITS'(i + 1);
            end
        end
    end

    // Clamp into the last bucket when the store is short.
    assign bucket = (int'(fls) >= BUCKET_COUNT) ? IDX_BITS'(BUCKET_COUNT - 1)
                                                : IDX_BITS'(fls);

endmodule

// File: hdl/log2h_bucket_store.sv
module log2h_bucket_store
    import log2h_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  store_rd_t             rd,
    input  store_wr_t             wr,
    output logic [COUNT_BITS-1:0] rd_data
);

`include "assert_macros.svh"

    logic [COUNT_BITS-1:0]   mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] valid_reg;
    logic [COUNT_BITS-1:0]   rd_data_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Write-first: a read that hits this cycle's write takes the new count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (rd.en) begin
            if (wr.en && wr.addr == rd.addr) begin
                rd_vld_reg <= 1'b1;
            end else begin
                rd_vld_reg <= valid_reg[rd.addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            if (wr.en && wr.addr == rd.addr) begin
                rd_data_reg <= wr.data;
            end else begin
                rd_data_reg <= mem[rd.addr];
            end
        end
    end

    // Never-written buckets read as zero.
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

    `ASSERT_NXT(a_fwd_hit, aclk, aresetn, rd.en && wr.en && rd.addr == wr.addr,
        rd_data == $past(wr.data), "read colliding with write lost the new count")
    `ASSERT_NXT(a_wr_valid, aclk, aresetn, wr.en, valid_reg[$past(wr.addr)],
        "written bucket not marked valid")

endmodule
